/* hw/rtl/nlcc_pkg.sv */
// Shared types, character codes and prefix table for the line checksum checker.
package nlcc_pkg;

	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_STAR = 8'h2A;

	localparam int PREFIX_LEN   = 6;
	localparam int PREFIX_COUNT = 6;
	localparam int LEN_W        = 7;

	localparam logic [LEN_W-1:0] MIN_LEN_RESET = 7'd10;

	// Known sentence prefixes, entry k reports sentence kind k+1
	localparam logic [0:PREFIX_COUNT-1][8*PREFIX_LEN-1:0] PREFIX_STR = {
		"$GPRMC", "$GPVTG", "$GPGGA", "$GPGSA", "$GPGSV", "$GPGLL"
	};

	localparam logic [2:0] KIND_OTHER = 3'd0;

	typedef enum logic [1:0] {
		ST_ACCEPTED  = 2'd0,
		ST_TOO_SHORT = 2'd1,
		ST_NO_STAR   = 2'd2,
		ST_MISMATCH  = 2'd3
	} status_t;

	typedef struct packed {
		status_t          line_status;
		logic [2:0]       sentence_kind;
		logic [7:0]       computed_sum;
		logic [7:0]       received_sum;
		logic [LEN_W-1:0] line_length;
	} result_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} hex_digit_t;

	// Decode one ASCII hex digit
	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.is_hex = 1'b1;
		d.value  = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			d.value = 4'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			d.value = 4'(c - 8'h57);
		end else if (c inside {[8'h41:8'h46]}) begin
			d.value = 4'(c - 8'h37);
		end else begin
			d.is_hex = 1'b0;
		end
		return d;
	endfunction

endpackage

/* hw/rtl/nlcc_line_tracker.sv */
// Per-line running state: length, XOR, star capture, hex parse and prefix match.
module nlcc_line_tracker import nlcc_pkg::*; #(
	parameter int LINE_CAPACITY = 128,
	parameter int CNT_W         = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  logic [LEN_W-1:0] min_line_length,
	output result_t          result
);

	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CAPACITY - 1);

	logic [CNT_W-1:0]        byte_count_q;
	logic [7:0]              running_xor_q;
	logic                    star_seen_q;
	logic [7:0]              xor_at_star_q;
	logic [7:0]              hex_value_q;
	logic                    hex_active_q;
	logic [PREFIX_COUNT-1:0] prefix_match_q;

	logic [CMP_W-1:0]        count_ext;
	logic [CMP_W-1:0]        min_ext;
	logic                    is_lf;
	logic                    is_cr;
	logic                    is_star;
	logic                    at_capacity;
	logic                    in_prefix;
	logic [2:0]              prefix_pos;
	logic [PREFIX_COUNT-1:0] prefix_next;
	hex_digit_t              digit;

	assign count_ext   = CMP_W'(byte_count_q);
	assign min_ext     = CMP_W'(min_line_length);
	assign is_lf       = (rx_byte == CHAR_LF);
	assign is_cr       = (rx_byte == CHAR_CR);
	assign is_star     = (rx_byte == CHAR_STAR);
	assign at_capacity = (byte_count_q == CNT_LAST);
	assign in_prefix   = (count_ext < CMP_W'(PREFIX_LEN));
	assign prefix_pos  = byte_count_q[2:0];
	assign digit       = hex_decode(rx_byte);

	// Drop prefixes whose character at this position differs
	always_comb begin
		prefix_next = prefix_match_q;
		for (int k = 0; k < PREFIX_COUNT; k++) begin
			if (PREFIX_STR[k][(PREFIX_LEN - 1 - int'(prefix_pos)) * 8 +: 8] != rx_byte) begin
				prefix_next[k] = 1'b0;
			end
		end
	end

	// Form the line-end report from the current state
	always_comb begin
		result.sentence_kind = KIND_OTHER;
		if (count_ext >= CMP_W'(PREFIX_LEN)) begin
			for (int k = PREFIX_COUNT - 1; k >= 0; k--) begin
				if (prefix_match_q[k]) begin
					result.sentence_kind = 3'(k + 1);
				end
			end
		end
		result.computed_sum = 8'd0;
		result.received_sum = 8'd0;
		result.line_length  = count_ext[LEN_W-1:0];
		if (count_ext <= min_ext) begin
			result.line_status   = ST_TOO_SHORT;
			result.sentence_kind = KIND_OTHER;
		end else if (!star_seen_q) begin
			result.line_status = ST_NO_STAR;
		end else begin
			result.computed_sum = xor_at_star_q;
			result.received_sum = hex_value_q;
			result.line_status  = (xor_at_star_q == hex_value_q) ? ST_ACCEPTED : ST_MISMATCH;
		end
	end

	// Advance the line state by one byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			running_xor_q  <= '0;
			star_seen_q    <= 1'b0;
			xor_at_star_q  <= '0;
			hex_value_q    <= '0;
			hex_active_q   <= 1'b0;
			prefix_match_q <= '1;
		end else if (step && !is_cr) begin
			if (is_lf || at_capacity) begin
				byte_count_q   <= '0;
				running_xor_q  <= '0;
				star_seen_q    <= 1'b0;
				xor_at_star_q  <= '0;
				hex_value_q    <= '0;
				hex_active_q   <= 1'b0;
				prefix_match_q <= '1;
			end else begin
				if (in_prefix) begin
					prefix_match_q <= prefix_next;
				end
				if (is_star) begin
					xor_at_star_q <= running_xor_q;
					star_seen_q   <= 1'b1;
					hex_active_q  <= 1'b1;
					hex_value_q   <= '0;
				end else if (hex_active_q) begin
					if (digit.is_hex) begin
						hex_value_q <= {hex_value_q[3:0], digit.value};
					end else begin
						hex_active_q <= 1'b0;
					end
				end
				if (byte_count_q != '0) begin
					running_xor_q <= running_xor_q ^ rx_byte;
				end
				byte_count_q <= byte_count_q + CNT_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/nmea_line_checksum_checker.sv */
// Top level: input byte register, line tracker and line report register.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  input   | in_valid / in_stall  | rx_byte
//  output  | out_valid/ out_stall | line_status, sentence_kind, computed_sum,
//          |                      | received_sum, line_length
//  config  | min_line_length_we   | min_line_length_wdata
//
// One byte per cycle sustained while no line feed is held back; each byte waits in the
// input register and the line state is updated as it leaves, so a line report is loaded
// into the report register as its line feed leaves the input register. Reset clears the
// line state and sets the minimum length to ten. A stalled report holds only a following
// line feed in the input register; other bytes keep flowing until they queue behind it.
module nmea_line_checksum_checker import nlcc_pkg::*; #(
	parameter int LINE_CAPACITY = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       line_status,
	output logic [2:0]       sentence_kind,
	output logic [7:0]       computed_sum,
	output logic [7:0]       received_sum,
	output logic [LEN_W-1:0] line_length,
	input  logic             min_line_length_we,
	input  logic [LEN_W-1:0] min_line_length_wdata
);

	localparam int CNT_W = $clog2(LINE_CAPACITY);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [LEN_W-1:0] min_len_q;
	logic             out_valid_q;
	result_t          res_q;
	result_t          res_next;
	logic             lf_s1;
	logic             advance;
	logic             in_xfer;
	logic             out_xfer;

	assign lf_s1    = (byte_s1 == CHAR_LF);
	assign out_xfer = out_valid_q && !out_stall;
	assign advance  = valid_s1 && !(lf_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// Hold the minimum length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RESET;
		end else if (min_line_length_we) begin
			min_len_q <= min_line_length_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= rx_byte;
		end
	end

	nlcc_line_tracker #(
		.LINE_CAPACITY (LINE_CAPACITY),
		.CNT_W         (CNT_W)
	) u_tracker (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.rx_byte         (byte_s1),
		.min_line_length (min_len_q),
		.result          (res_next)
	);

	// Report register: load on a line feed, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && lf_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && lf_s1) begin
			res_q <= res_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign line_status   = res_q.line_status;
	assign sentence_kind = res_q.sentence_kind;
	assign computed_sum  = res_q.computed_sum;
	assign received_sum  = res_q.received_sum;
	assign line_length   = res_q.line_length;

	// A new report comes only from a line feed in the input register
	a_report_from_lf: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(lf_s1))
		else $error("report raised without a line feed");

	// Input stalls only behind a line feed blocked by a waiting report
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && lf_s1 && out_valid_q))
		else $error("input stalled without cause");

	// An accepted line has matching sums
	a_accept_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.line_status == ST_ACCEPTED) |->
		(res_q.computed_sum == res_q.received_sum))
		else $error("accepted line with differing sums");

	// A short line reports no kind and no sums
	a_short_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.line_status == ST_TOO_SHORT) |->
		(res_q.sentence_kind == KIND_OTHER && res_q.computed_sum == 8'd0 &&
		 res_q.received_sum == 8'd0))
		else $error("short line carries kind or sums");

endmodule
